// ===== rtl/core/wsfp_pkg.sv =====
// Shared types and constants for the WebSocket frame parser.
package wsfp_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 16;
	localparam int unsigned Len7W  = 7;

	localparam logic [ByteW-1:0] FinMask    = 8'h80;
	localparam logic [ByteW-1:0] MaskBit    = 8'h80;
	localparam logic [3:0]       OpText     = 4'h1;
	localparam logic [Len7W-1:0] Len7Ext16  = 7'd126;
	localparam logic [Len7W-1:0] Len7Ext64  = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXT_HI = 3'd2,
		PH_EXT_LO = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	typedef struct packed {
		logic             has_result;
		logic [ByteW-1:0] payload_byte;
		logic             byte_valid;
		logic             frame_end;
		logic             unsupported;
	} result_t;

endpackage

// ===== rtl/core/wsfp_parser.sv =====
// Frame parser state machine: header checks, length capture and payload count.
module wsfp_parser
	import wsfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [ByteW-1:0] rx_byte,
	output result_t          result
);

	phase_t              phase_q, phase_d;
	logic [ByteW-1:0]    first_header_q, first_header_d;
	logic [CountW-1:0]   remaining_q, remaining_d;

	logic [Len7W-1:0]    len7;
	logic                hdr_ok;
	logic                last_data;
	logic [CountW-1:0]   ext_count;

	assign len7      = rx_byte[Len7W-1:0];
	assign hdr_ok    = ((first_header_q & FinMask) != '0)
	                && (first_header_q[3:0] == OpText)
	                && ((rx_byte & MaskBit) == '0)
	                && (len7 != Len7Ext64);
	assign last_data = (remaining_q <= CountW'(1));
	assign ext_count = remaining_q | CountW'(rx_byte);

	// next state
	always_comb begin
		phase_d        = phase_q;
		first_header_d = first_header_q;
		remaining_d    = remaining_q;
		unique case (phase_q)
			PH_HDR1: begin
				if (!hdr_ok) begin
					phase_d = PH_HDR0;
				end else if (len7 == Len7Ext16) begin
					phase_d = PH_EXT_HI;
				end else if (len7 == '0) begin
					phase_d = PH_HDR0;
				end else begin
					remaining_d = CountW'(len7);
					phase_d     = PH_DATA;
				end
			end
			PH_EXT_HI: begin
				remaining_d = {rx_byte, {(CountW-ByteW){1'b0}}};
				phase_d     = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				remaining_d = ext_count;
				phase_d     = (ext_count == '0) ? PH_HDR0 : PH_DATA;
			end
			PH_DATA: begin
				remaining_d = last_data ? '0 : remaining_q - CountW'(1);
				if (last_data) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				first_header_d = rx_byte;
				phase_d        = PH_HDR1;
			end
		endcase
	end

	// result for the current beat
	always_comb begin
		result = '0;
		unique case (phase_q)
			PH_HDR1: begin
				if (!hdr_ok) begin
					result.has_result  = 1'b1;
					result.unsupported = 1'b1;
				end else if (len7 == '0) begin
					result.has_result = 1'b1;
					result.frame_end  = 1'b1;
				end
			end
			PH_EXT_LO: begin
				if (ext_count == '0) begin
					result.has_result = 1'b1;
					result.frame_end  = 1'b1;
				end
			end
			PH_DATA: begin
				result.has_result   = 1'b1;
				result.payload_byte = rx_byte;
				result.byte_valid   = 1'b1;
				result.frame_end    = last_data;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR0;
			first_header_q <= '0;
			remaining_q    <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			first_header_q <= first_header_d;
			remaining_q    <= remaining_d;
		end
	end

endmodule

// ===== rtl/core/websocket_frame_parser_top.sv =====
// WebSocket frame parser: input byte register, parser, result register.
// A byte goes through the input byte register, then the result register.
// Throughput: one byte per cycle while the output side is ready; the result
// register frees the input stage as soon as the held result is taken.
// Reset (arst_n low, asynchronous): parser expects a first header byte,
// both stages are emptied.
module websocket_frame_parser_top
	import wsfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [ByteW-1:0] m_axis_tdata,  // [7:0] payload_byte
	output logic [1:0]       m_axis_tuser,  // [0] byte_valid, [1] unsupported
	output logic             m_axis_tlast   // frame_end
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_free;
	logic             step;
	result_t          result;

	// the result register is free when empty or being drained this cycle
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	wsfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= step && result.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.has_result) begin
			m_axis_tdata <= result.payload_byte;
			m_axis_tuser <= {result.unsupported, result.byte_valid};
			m_axis_tlast <= result.frame_end;
		end
	end

endmodule

// ===== rtl/core/wsfp_checker.sv =====
// Port-level checks for the WebSocket frame parser, bound to the top level.
module wsfp_checker
	import wsfp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [ByteW-1:0] m_axis_tdata,
	input logic [1:0]       m_axis_tuser,
	input logic             m_axis_tlast
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("payload beat flagged unsupported");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tlast && (m_axis_tdata == '0))
		else $error("reject beat carries data or end");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1]
			|-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("non-payload beat is not an empty frame end");

	// a free output side never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind websocket_frame_parser_top wsfp_checker u_wsfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the WebSocket frame parser stream wrapper.
`timescale 1ns / 1ps

module tb_top;
	import wsfp_pkg::*;

	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned HoldStart = 400;
	localparam int unsigned HoldLen   = 300;

	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		logic             byte_valid;
		logic             frame_end;
		logic             unsupported;
	} beat_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [ByteW-1:0] s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [ByteW-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;
	logic             m_axis_tlast;

	// parser state mirrored by the predictor
	phase_t            hdr_phase = PH_HDR0;
	logic [ByteW-1:0]  hdr0_byte = '0;
	logic [CountW-1:0] bytes_left = '0;

	logic [ByteW-1:0] tx_bytes[$];
	beat_t            parsed_q[$];

	bit          byte_taken = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned bytes_in = 0;
	int unsigned idle_cycles = 0;
	int unsigned errors = 0;
	logic [9:0]  cycle_cnt = '0;
	wire         calm = (cycle_cnt[9:8] == 2'b11);

	websocket_frame_parser_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #2 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the parser model by one received byte and queue any result.
	function automatic void parse_byte(input logic [ByteW-1:0] b);
		beat_t            r;
		logic [Len7W-1:0] len7;
		logic             last;
		r = '0;
		len7 = b[Len7W-1:0];
		case (hdr_phase)
			PH_HDR1: begin
				if ((hdr0_byte & FinMask) == '0 || hdr0_byte[3:0] != OpText
						|| (b & MaskBit) != '0 || len7 == Len7Ext64) begin
					hdr_phase = PH_HDR0;
					r.unsupported = 1'b1;
					parsed_q.push_back(r);
				end else if (len7 == Len7Ext16) begin
					hdr_phase = PH_EXT_HI;
				end else if (len7 == '0) begin
					hdr_phase = PH_HDR0;
					r.frame_end = 1'b1;
					parsed_q.push_back(r);
				end else begin
					bytes_left = CountW'(len7);
					hdr_phase = PH_DATA;
				end
			end
			PH_EXT_HI: begin
				bytes_left = {b, 8'h00};
				hdr_phase = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				bytes_left = bytes_left | CountW'(b);
				if (bytes_left == '0) begin
					hdr_phase = PH_HDR0;
					r.frame_end = 1'b1;
					parsed_q.push_back(r);
				end else begin
					hdr_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				last = (bytes_left <= 1);
				bytes_left = last ? '0 : bytes_left - 1'b1;
				if (last)
					hdr_phase = PH_HDR0;
				r.payload_byte = b;
				r.byte_valid = 1'b1;
				r.frame_end = last;
				parsed_q.push_back(r);
			end
			default: begin
				hdr0_byte = b;
				hdr_phase = PH_HDR1;
			end
		endcase
	endfunction

	// Queue a well-formed text frame with random reserved bits and payload.
	task automatic add_frame(input int unsigned len, input bit ext);
		logic [ByteW-1:0]  hdr;
		logic [CountW-1:0] n;
		hdr = FinMask | ByteW'(OpText) | (ByteW'($urandom_range(0, 7)) << 4);
		n = CountW'(len);
		tx_bytes.push_back(hdr);
		if (ext || len > 125) begin
			tx_bytes.push_back(ByteW'(Len7Ext16));
			tx_bytes.push_back(n[15:8]);
			tx_bytes.push_back(n[7:0]);
		end else begin
			tx_bytes.push_back(ByteW'(n[Len7W-1:0]));
		end
		for (int unsigned i = 0; i < len; i++)
			tx_bytes.push_back(ByteW'($urandom_range(0, 255)));
	endtask

	// Queue a header that fails one of the checks, or a random pair.
	task automatic add_bad_header();
		logic [3:0] op;
		case ($urandom_range(0, 4))
			0: begin
				tx_bytes.push_back(ByteW'($urandom_range(0, 255)) & ~FinMask);
				tx_bytes.push_back(ByteW'($urandom_range(0, 255)));
			end
			1: begin
				op = 4'($urandom_range(2, 16));
				tx_bytes.push_back(FinMask | ByteW'(op) | (ByteW'($urandom_range(0, 7)) << 4));
				tx_bytes.push_back(ByteW'($urandom_range(0, 125)));
			end
			2: begin
				tx_bytes.push_back(FinMask | ByteW'(OpText));
				tx_bytes.push_back(MaskBit | ByteW'($urandom_range(0, 127)));
			end
			3: begin
				tx_bytes.push_back(FinMask | ByteW'(OpText));
				tx_bytes.push_back(ByteW'(Len7Ext64));
			end
			default: begin
				tx_bytes.push_back(ByteW'($urandom_range(0, 255)));
				tx_bytes.push_back(ByteW'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// Directed part: empty frame, each rejected header, reserved bits,
	// extended length of zero and of one, payload extremes.
	logic [ByteW-1:0] directed[25] = '{
		8'h81, 8'h00,
		8'h01, 8'h05,
		8'h82, 8'h05,
		8'h81, 8'h85,
		8'h81, 8'h7F,
		8'hF1, 8'h01, 8'hAB,
		8'h81, 8'h7E, 8'h00, 8'h00,
		8'h81, 8'h7E, 8'h00, 8'h01, 8'hFF,
		8'h81, 8'h01, 8'h00
	};

	initial begin
		int unsigned r;
		foreach (directed[i])
			tx_bytes.push_back(directed[i]);
		while (tx_bytes.size() < 1100) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				add_bad_header();
			else if (r < 13)
				add_frame(0, 1'($urandom_range(0, 1)));
			else if (r < 20)
				add_frame(($urandom_range(0, 9) == 0) ? $urandom_range(256, 520)
						: $urandom_range(1, 140), 1'b1);
			else if (r < 23)
				add_frame(125, 1'b0);
			else
				add_frame($urandom_range(1, 24), 1'b0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() > 0 || s_axis_tvalid || parsed_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (parsed_q.size() != 0)
			errors++;
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Sample both handshakes, predict, compare, and watch for a hang.
	always @(posedge clk) begin
		beat_t want;
		if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1'b1;
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata);
				byte_taken = 1'b1;
				bytes_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (parsed_q.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual data %h user %b last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = parsed_q.pop_front();
					if (m_axis_tdata != want.payload_byte) begin
						$display("%0t: payload_byte expected %h actual %h",
							$time, want.payload_byte, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser[0] != want.byte_valid) begin
						$display("%0t: byte_valid expected %b actual %b",
							$time, want.byte_valid, m_axis_tuser[0]);
						errors++;
					end
					if (m_axis_tlast != want.frame_end) begin
						$display("%0t: frame_end expected %b actual %b",
							$time, want.frame_end, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser[1] != want.unsupported) begin
						$display("%0t: unsupported expected %b actual %b",
							$time, want.unsupported, m_axis_tuser[1]);
						errors++;
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Sender: offer the next byte once the current one is taken, with gaps.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			byte_taken = 1'b0;
			if (calm)
				gap_left = 0;
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (tx_bytes.size() > 0) begin
				s_axis_tdata <= tx_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				gap_left = calm ? 0 : pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold to back up the input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && bytes_in >= HoldStart) begin
				hold_done = 1'b1;
				hold_left = HoldLen - 1;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				stall_left = 0;
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== websocket_frame_parser_top.f =====
rtl/core/wsfp_pkg.sv
rtl/core/wsfp_parser.sv
rtl/core/websocket_frame_parser_top.sv
rtl/core/wsfp_checker.sv
verif/tb_top.sv
